[design/salc_pkg.sv]
// Shared constants, codes and types for the set-associative LRU cache model.
`default_nettype none
package salc_pkg;

   localparam int MAX_SET_BITS_C = 8;
   localparam int MAX_WAYS_C     = 8;
   localparam int STAMP_W        = 32;
   localparam int TAG_W          = 32;
   localparam int ADDR_W         = 32;
   localparam int CNT_W          = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_WAYS_USED  = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd2;

   localparam logic [3:0] SET_BITS_RST   = 4'd4;
   localparam logic [3:0] WAYS_USED_RST  = 4'd1;
   localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

   typedef struct packed {
      logic [3:0] set_bits;
      logic [3:0] ways_used;
      logic [4:0] block_bits;
   } cfg_type;

endpackage
`default_nettype wire

[design/set_assoc_lru_cache_sim_core.sv]
// An accepted item passes through the queue, the set read (ISSUE) and the update (EXEC) to rsp.
// The back end handles one item at a time, set by the single row RAM: a read state, then a
//   compare/update/write state per access; the queue still takes new items while not full.
// Reset clears counters, the access clock and the per-set valid bits; the line RAM
//   is not swept, so items are taken right after reset. Registers return to 4 / 1 / 4.
`default_nettype none
module set_assoc_lru_cache_sim_core
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_C,
   parameter int MAX_WAYS     = MAX_WAYS_C
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [ADDR_W-1:0] req_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_lookup_hit,
   output logic                   rsp_lookup_evicted,
   output logic      [CNT_W-1:0]  rsp_hit_total,
   output logic      [CNT_W-1:0]  rsp_miss_total,
   output logic      [CNT_W-1:0]  rsp_eviction_total,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [4:0]        csr_data
);
   localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ENTRY_W = 2 + SET_W + TAG_W;

   cfg_type cfg_ff;
   logic    q_full, q_push, q_pop, q_not_empty;
   logic [ENTRY_W-1:0] q_entry, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits   <= SET_BITS_RST;
         cfg_ff.ways_used  <= WAYS_USED_RST;
         cfg_ff.block_bits <= BLOCK_BITS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SET_BITS:   cfg_ff.set_bits   <= csr_data[3:0];
            CSR_WAYS_USED:  cfg_ff.ways_used  <= csr_data[3:0];
            CSR_BLOCK_BITS: cfg_ff.block_bits <= csr_data;
            default: ;
         endcase
      end
   end

   salc_front #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_addr  (req_addr),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   salc_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   salc_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lookup_hit     (rsp_lookup_hit),
      .rsp_lookup_evicted (rsp_lookup_evicted),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );
endmodule
`default_nettype wire

[design/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]              wr_data,
   input  wire logic                          rd_en,
   input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/salc_queue.sv]
// Small FIFO between the classify front and the lookup back end.
`default_nettype none
module salc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic      [WIDTH-1:0] head
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

[design/salc_front.sv]
// Front end: accepts accesses and splits the address into set index and tag.
`default_nettype none
module salc_front
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_C,
   parameter int ENTRY_W      = 2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + TAG_W
) (
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_op,
   input  wire logic [ADDR_W-1:0]    req_addr,
   input  wire cfg_type              cfg,
   input  wire logic                 q_full,
   output logic                      q_push,
   output logic      [ENTRY_W-1:0]   q_entry
);
   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   logic [4:0]        sb;
   logic [5:0]        split;
   logic [ADDR_W-1:0] shifted;
   logic [ADDR_W-1:0] set_mask;
   logic [SET_W-1:0]  set_idx;
   logic [TAG_W-1:0]  tag;
   logic              do_access;
   logic              is_modify;

   always_comb begin
      sb = ({1'b0, cfg.set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, cfg.set_bits};
      split    = {1'b0, cfg.block_bits} + {1'b0, sb};
      shifted  = req_addr >> cfg.block_bits;
      set_mask = ~({ADDR_W{1'b1}} << sb);
      set_idx  = SET_W'(shifted & set_mask);
      tag      = (split >= 6'd32) ? '0 : TAG_W'(req_addr >> split);
      do_access = (req_op == OP_LOAD) || (req_op == OP_STORE) || (req_op == OP_MODIFY);
      is_modify = (req_op == OP_MODIFY);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = {do_access, is_modify, set_idx, tag};
endmodule
`default_nettype wire

[design/salc_back.sv]
// Back end: reads a set, does the tag match and LRU pick, writes back, counts.
`default_nettype none
module salc_back
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_C,
   parameter int MAX_WAYS     = MAX_WAYS_C,
   parameter int ENTRY_W      = 2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + TAG_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               q_not_empty,
   input  wire logic [ENTRY_W-1:0] q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_lookup_hit,
   output logic                    rsp_lookup_evicted,
   output logic      [CNT_W-1:0]   rsp_hit_total,
   output logic      [CNT_W-1:0]   rsp_miss_total,
   output logic      [CNT_W-1:0]   rsp_eviction_total
);
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LINE_W   = STAMP_W + TAG_W;
   localparam int ROW_W    = MAX_WAYS * LINE_W;

   localparam logic ST_ISSUE = 1'b0;
   localparam logic ST_EXEC  = 1'b1;

   logic              state_ff, state_in;
   logic              cur_access_ff, cur_modify_ff, row_ok_ff;
   logic [SET_W-1:0]  cur_set_ff;
   logic [TAG_W-1:0]  cur_tag_ff;
   logic [NUM_SETS-1:0] row_valid_ff;
   logic [STAMP_W-1:0] clk_ff, clk_in;
   logic [CNT_W-1:0]  hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;
   logic              rsp_valid_ff;
   logic              hit_out_ff, evict_out_ff;

   logic              q_access, q_modify;
   logic [SET_W-1:0]  q_set;
   logic [TAG_W-1:0]  q_tag;

   logic [ROW_W-1:0]  rd_row, wr_row;
   logic              go, wr_en;
   logic [6:0]        ways;
   logic [STAMP_W-1:0] stamp [MAX_WAYS];
   logic [TAG_W-1:0]  ltag  [MAX_WAYS];
   logic [MAX_WAYS-1:0] in_rng, hitv, freev, oldv;
   logic              any_hit, any_free;
   logic [WAY_W-1:0]  hit_idx, free_idx, old_idx, pick;
   logic [1:0]        hit_add;
   logic [CNT_W:0]    hsum;

   assign {q_access, q_modify, q_set, q_tag} = q_head;

   assign q_pop = (state_ff == ST_ISSUE) && q_not_empty;
   assign go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en = go && cur_access_ff;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_set_ff),
      .wr_data (wr_row),
      .rd_en   (q_pop),
      .rd_addr (q_set),
      .rd_data (rd_row)
   );

   always_comb begin
      ways = (cfg.ways_used == 4'd0) ? 7'd1 : {3'b0, cfg.ways_used};
      if (ways > 7'(MAX_WAYS)) begin
         ways = 7'(MAX_WAYS);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         // a set never written reads as all lines invalid
         stamp[w]  = row_ok_ff ? rd_row[w*LINE_W +: STAMP_W] : '0;
         ltag[w]   = rd_row[w*LINE_W + STAMP_W +: TAG_W];
         in_rng[w] = (w < int'(ways));
         hitv[w]   = in_rng[w] && (stamp[w] != '0) && (ltag[w] == cur_tag_ff);
         freev[w]  = in_rng[w] && (stamp[w] == '0);
      end
      // oldest line: strictly older than lower ways, no newer than higher ways
      for (int w = 0; w < MAX_WAYS; w++) begin
         oldv[w] = in_rng[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (in_rng[v]) begin
               if (v < w) begin
                  oldv[w] = oldv[w] && (stamp[w] < stamp[v]);
               end else begin
                  oldv[w] = oldv[w] && (stamp[w] <= stamp[v]);
               end
            end
         end
      end
      any_hit  = |hitv;
      any_free = |freev;
      hit_idx  = '0;
      free_idx = '0;
      old_idx  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hitv[w]) begin
            hit_idx = WAY_W'(w);
         end
         if (freev[w]) begin
            free_idx = WAY_W'(w);
         end
         if (oldv[w]) begin
            old_idx = WAY_W'(w);
         end
      end
      pick = any_hit ? hit_idx : (any_free ? free_idx : old_idx);

      clk_in = (clk_ff == '1) ? clk_ff : clk_ff + 1'b1;

      for (int w = 0; w < MAX_WAYS; w++) begin
         wr_row[w*LINE_W +: STAMP_W]         = stamp[w];
         wr_row[w*LINE_W + STAMP_W +: TAG_W] = ltag[w];
         if (WAY_W'(w) == pick) begin
            wr_row[w*LINE_W +: STAMP_W] = clk_in;
            if (!any_hit) begin
               wr_row[w*LINE_W + STAMP_W +: TAG_W] = cur_tag_ff;
            end
         end
      end

      // a modify counts one extra hit ahead of its own lookup
      hit_add = {1'b0, cur_modify_ff} + {1'b0, any_hit};
      hsum    = {1'b0, hits_ff} + (CNT_W+1)'(hit_add);
      hits_in   = hsum[CNT_W] ? '1 : hsum[CNT_W-1:0];
      misses_in = (any_hit || misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
      evicts_in = (any_hit || any_free || evicts_ff == '1) ? evicts_ff : evicts_ff + 1'b1;

      state_in = state_ff;
      unique case (state_ff)
         ST_ISSUE: if (q_not_empty) state_in = ST_EXEC;
         ST_EXEC:  if (go) state_in = ST_ISSUE;
         default:  state_in = ST_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         row_valid_ff <= '0;
         clk_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            row_valid_ff[cur_set_ff] <= 1'b1;
            clk_ff    <= clk_in;
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            evicts_ff <= evicts_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_access_ff <= q_access;
         cur_modify_ff <= q_modify;
         cur_set_ff    <= q_set;
         cur_tag_ff    <= q_tag;
         row_ok_ff     <= row_valid_ff[q_set];
      end
      if (go) begin
         hit_out_ff   <= cur_access_ff && any_hit;
         evict_out_ff <= cur_access_ff && !any_hit && !any_free;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lookup_hit     = hit_out_ff;
   assign rsp_lookup_evicted = evict_out_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evicts_ff;
endmodule
`default_nettype wire

[design/salc_checker.sv]
// Port-level checks for the cache model core, bound to the top level.
`default_nettype none
module salc_checker
   import salc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic             rsp_lookup_hit,
   input wire logic             rsp_lookup_evicted,
   input wire logic [CNT_W-1:0] rsp_hit_total,
   input wire logic [CNT_W-1:0] rsp_miss_total,
   input wire logic [CNT_W-1:0] rsp_eviction_total
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_total)
         && $stable(rsp_lookup_hit) && $stable(rsp_lookup_evicted))
      else $error("stalled item changed");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lookup_evicted |-> !rsp_lookup_hit)
      else $error("item both hit and evicted");

   a_hit_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lookup_hit |-> rsp_hit_total != '0)
      else $error("hit with zero hit total");

   a_evict_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lookup_evicted |-> rsp_eviction_total != '0 && rsp_miss_total != '0)
      else $error("eviction not counted");

   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("item shown right after reset");
endmodule

bind set_assoc_lru_cache_sim_core salc_checker u_salc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_lookup_hit     (rsp_lookup_hit),
   .rsp_lookup_evicted (rsp_lookup_evicted),
   .rsp_hit_total      (rsp_hit_total),
   .rsp_miss_total     (rsp_miss_total),
   .rsp_eviction_total (rsp_eviction_total)
);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the set-associative LRU cache simulator core.
`default_nettype none
module testbench;
   import salc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_LOAD;
   logic [31:0] req_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_lookup_hit, rsp_lookup_evicted;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_eviction_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SET_BITS;
   logic [4:0]  csr_data = '0;

   set_assoc_lru_cache_sim_core u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } lookup_t;

   // shadow cache state
   logic [31:0] tag_mem   [256][8];
   logic [31:0] stamp_mem [256][8];
   logic [31:0] clk_stamp, hit_cnt, miss_cnt, evict_cnt;
   logic [3:0]  cfg_sets, cfg_ways;
   logic [4:0]  cfg_block;

   lookup_t lookup_q[$];
   int      errors = 0;
   int      in_flight_gap = 0;
   bit      no_idle = 1'b0;

   function automatic logic [31:0] sat1(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   function automatic lookup_t cache_access(logic [1:0] op, logic [31:0] addr);
      lookup_t r;
      int sb, ways, set, pick;
      logic [31:0] tag;
      bit found;
      r = '0;
      if (op != 2'd3) begin
         sb   = (cfg_sets > 8) ? 8 : cfg_sets;
         ways = (cfg_ways == 0) ? 1 : ((cfg_ways > 8) ? 8 : cfg_ways);
         set  = ((addr >> cfg_block) & ((32'd1 << sb) - 1)) & 255;
         tag  = (cfg_block + sb >= 32) ? 32'd0 : (addr >> (cfg_block + sb));
         found = 1'b0;
         if (op == OP_MODIFY) hit_cnt = sat1(hit_cnt);
         clk_stamp = sat1(clk_stamp);
         for (int w = 0; w < ways; w++) begin
            if (!found && stamp_mem[set][w] != 0 && tag_mem[set][w] == tag) begin
               stamp_mem[set][w] = clk_stamp;
               found = 1'b1;
            end
         end
         r.hit = found;
         if (found) begin
            hit_cnt = sat1(hit_cnt);
         end else begin
            miss_cnt = sat1(miss_cnt);
            pick = ways;
            for (int w = ways - 1; w >= 0; w--)
               if (stamp_mem[set][w] == 0) pick = w;
            if (pick == ways) begin
               pick = 0;
               for (int w = 1; w < ways; w++)
                  if (stamp_mem[set][w] < stamp_mem[set][pick]) pick = w;
               r.evicted = 1'b1;
               evict_cnt = sat1(evict_cnt);
            end
            stamp_mem[set][pick] = clk_stamp;
            tag_mem[set][pick]   = tag;
         end
      end
      r.hits = hit_cnt;
      r.misses = miss_cnt;
      r.evictions = evict_cnt;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      errors++;
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      lookup_t e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (lookup_q.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               e = lookup_q.pop_front();
               if (rsp_lookup_hit !== e.hit) report_mismatch("hit", rsp_lookup_hit, e.hit);
               if (rsp_lookup_evicted !== e.evicted)
                  report_mismatch("evicted", rsp_lookup_evicted, e.evicted);
               if (rsp_hit_total !== e.hits) report_mismatch("hit_total", rsp_hit_total, e.hits);
               if (rsp_miss_total !== e.misses)
                  report_mismatch("miss_total", rsp_miss_total, e.misses);
               if (rsp_eviction_total !== e.evictions)
                  report_mismatch("eviction_total", rsp_eviction_total, e.evictions);
            end
         end
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 11);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SET_BITS:   cfg_sets  = val[3:0];
         CSR_WAYS_USED:  cfg_ways  = val[3:0];
         CSR_BLOCK_BITS: cfg_block = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (lookup_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   // one item; holds valid across back-to-back items, expected value may be forced
   task automatic send(logic [1:0] op, logic [31:0] addr, bit last);
      lookup_t e;
      if (!no_idle) begin
         while ($urandom_range(99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_addr  <= addr;
      do @(posedge clock); while (req_stall);
      e = cache_access(op, addr);
      lookup_q.push_back(e);
      if (last) req_valid <= 1'b0;
   endtask

   typedef struct {
      logic [1:0]  op;
      logic [31:0] addr;
      bit          fixed;
      logic        hit, evicted;
      logic [31:0] h, m, ev;
   } stim_row_t;

   // reset config: 4 set bits, 1 way, 16-byte blocks
   stim_row_t directed[] = '{
      '{OP_LOAD,   32'h0000_0000, 1, 0, 0, 0, 1, 0},
      '{OP_LOAD,   32'h0000_000F, 1, 1, 0, 1, 1, 0},
      '{OP_STORE,  32'h0000_0100, 1, 0, 1, 1, 2, 1},
      '{OP_MODIFY, 32'h0000_0100, 1, 1, 0, 3, 2, 1},
      '{2'd3,      32'hFFFF_FFFF, 1, 0, 0, 3, 2, 1},
      '{OP_LOAD,   32'hFFFF_FFFF, 1, 0, 0, 3, 3, 1},
      '{OP_MODIFY, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0},
      '{OP_STORE,  32'h8000_0000, 0, 0, 0, 0, 0, 0},
      '{OP_LOAD,   32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{OP_MODIFY, 32'h0000_0010, 0, 0, 0, 0, 0, 0},
      '{OP_LOAD,   32'h0000_0000, 0, 0, 0, 0, 0, 0}
   };

   task automatic rand_phase(int n, int tag_span);
      logic [1:0]  op;
      logic [31:0] a;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(99) < 3) ? 2'd3 : 2'($urandom_range(2));
         if ($urandom_range(9) == 0) a = $urandom();
         else a = ($urandom_range(tag_span) << 14) ^ ($urandom_range(255) << cfg_block)
                  ^ $urandom_range(3);
         send(op, a, i == n - 1);
      end
   endtask

   initial begin
      lookup_t e;
      foreach (stamp_mem[s, w]) begin
         stamp_mem[s][w] = '0;
         tag_mem[s][w] = '0;
      end
      clk_stamp = 0; hit_cnt = 0; miss_cnt = 0; evict_cnt = 0;
      cfg_sets = SET_BITS_RST; cfg_ways = WAYS_USED_RST; cfg_block = BLOCK_BITS_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send(directed[i].op, directed[i].addr, i == directed.size() - 1);
         if (directed[i].fixed) begin
            e = lookup_q.pop_back();
            lookup_q.push_back({directed[i].hit, directed[i].evicted,
                                directed[i].h, directed[i].m, directed[i].ev});
         end
      end
      drain();

      // extremes: zero sets/oversized block, then over-range values
      write_reg(CSR_SET_BITS, 5'd0);
      write_reg(CSR_WAYS_USED, 5'd0);
      write_reg(CSR_BLOCK_BITS, 5'd31);
      rand_phase(40, 3);
      drain();
      write_reg(CSR_SET_BITS, 5'd15);
      write_reg(CSR_WAYS_USED, 5'd15);
      write_reg(CSR_BLOCK_BITS, 5'd0);
      rand_phase(300, 15);
      drain();
      write_reg(CSR_SET_BITS, 5'd8);
      write_reg(CSR_WAYS_USED, 5'd8);
      write_reg(CSR_BLOCK_BITS, 5'd16);
      rand_phase(300, 15);
      drain();
      write_reg(CSR_SET_BITS, 5'd24 + 5'd2);
      write_reg(CSR_WAYS_USED, 5'd4);
      write_reg(CSR_BLOCK_BITS, 5'd24);
      rand_phase(200, 7);
      drain();
      no_idle = 1'b1;
      write_reg(CSR_SET_BITS, 5'd2);
      write_reg(CSR_WAYS_USED, 5'd2);
      write_reg(CSR_BLOCK_BITS, 5'd5);
      rand_phase(400, 7);
      no_idle = 1'b0;
      drain();
      for (int p = 0; p < 7; p++) begin
         write_reg(CSR_SET_BITS, 5'($urandom_range(9)));
         write_reg(CSR_WAYS_USED, 5'($urandom_range(1, 9)));
         write_reg(CSR_BLOCK_BITS, 5'($urandom_range(16)));
         rand_phase(100, 31);
         drain();
      end
      drain();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
